// File: rtl/core/brr_pkg.sv
// Shared types and constants for the block reverse reorder design.
package brr_pkg;

   localparam int VALUE_W      = 60;
   localparam int GROUP_SIZE_W = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 7'd64;

   // Register index, taken from the word address bits of the CSR port.
   localparam logic [CSR_ADDR_W-3:0] REG_GROUP_SIZE = 1'b0;

   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic issue;    // read one buffered element toward the output
   } brr_cmd_type;

   typedef struct packed {
      logic flush;     // the element on the input closes a group
      logic rd_zero;   // read pointer is at the first element of the group
      logic out_free;  // output register can take new data this cycle
   } brr_status_type;

endpackage

// File: rtl/core/brr_ctrl.sv
// Controller state machine: alternates between filling a group and emitting it.
module brr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  brr_pkg::brr_status_type status,
   output brr_pkg::brr_cmd_type    cmd
);
   import brr_pkg::*;

   typedef enum logic {
      ST_FILL,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd.accept = req_valid & ready_ff;
      cmd.issue  = (state_ff == ST_EMIT) & status.out_free;
   end

   assign req_ready = ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_FILL: begin
               if (cmd.accept && status.flush) begin
                  state_ff <= ST_EMIT;
                  ready_ff <= 1'b0;
               end
            end
            ST_EMIT: begin
               // The read of the first buffered element ends the group, so the
               // buffer may take new elements while that result still waits.
               if (cmd.issue && status.rd_zero) begin
                  state_ff <= ST_FILL;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_FILL;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/brr_datapath.sv
// Datapath: group buffer, fill counter, read pointer and output register.
module brr_datapath #(
   parameter int MAX_GROUP = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  brr_pkg::brr_cmd_type               cmd,
   output brr_pkg::brr_status_type            status,
   input  logic [brr_pkg::GROUP_SIZE_W-1:0]   group_size,
   input  logic [brr_pkg::VALUE_W-1:0]        req_value,
   input  logic                               req_array_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [brr_pkg::VALUE_W-1:0]        rsp_out_value,
   output logic                               rsp_group_last,
   output logic                               rsp_array_last
);
   import brr_pkg::*;

   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int CMP_W = (CNT_W > GROUP_SIZE_W) ? CNT_W : GROUP_SIZE_W;

   logic [VALUE_W-1:0] mem [MAX_GROUP];

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   logic               last_ff, last_in;
   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff;
   logic               group_last_ff, array_last_ff;

   logic [CNT_W-1:0]   new_count;
   logic [CMP_W-1:0]   size_ext;
   logic [CMP_W-1:0]   eff_size;

   // A size of zero acts as one; a size above the buffer depth saturates.
   always_comb begin
      size_ext = CMP_W'(group_size);
      if (size_ext == '0) begin
         eff_size = CMP_W'(1);
      end else if (size_ext > CMP_W'(MAX_GROUP)) begin
         eff_size = CMP_W'(MAX_GROUP);
      end else begin
         eff_size = size_ext;
      end
   end

   assign new_count = fill_ff + CNT_W'(1);

   always_comb begin
      status.flush    = (CMP_W'(new_count) >= eff_size) | req_array_end;
      status.rd_zero  = (rd_addr_ff == '0);
      status.out_free = ~valid_ff | rsp_ready;
   end

   always_comb begin
      fill_in    = fill_ff;
      rd_addr_in = rd_addr_ff;
      last_in    = last_ff;
      if (cmd.accept) begin
         if (status.flush) begin
            fill_in    = '0;
            rd_addr_in = fill_ff[IDX_W-1:0];
            last_in    = req_array_end;
         end else begin
            fill_in = new_count;
         end
      end else if (cmd.issue) begin
         rd_addr_in = rd_addr_ff - IDX_W'(1);
      end
   end

   always_comb begin
      if (cmd.issue) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         rd_addr_ff <= '0;
         last_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         rd_addr_ff <= rd_addr_in;
         last_ff    <= last_in;
         valid_ff   <= valid_in;
      end
   end

   // The group is read back from the highest entry down; the registered read
   // data is the output register itself and holds while the sink stalls.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[fill_ff[IDX_W-1:0]] <= req_value;
      end
      if (cmd.issue) begin
         value_ff      <= mem[rd_addr_ff];
         group_last_ff <= status.rd_zero;
         array_last_ff <= status.rd_zero & last_ff;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_value  = value_ff;
   assign rsp_group_last = group_last_ff;
   assign rsp_array_last = array_last_ff;

endmodule

// File: rtl/core/block_reverse_reorder.sv
// Top level of the block reverse reorder: CSR port, controller and datapath.
//
// The block reverses each run of group_size consecutive elements of a stream
// (a final partial run, closed by an element with array_end set, is reversed
// as it stands). While a group fills, one element is taken per cycle and
// written into a MAX_GROUP-entry buffer. The element that closes a group
// stops the input, and the group then leaves one buffer read per cycle
// unless the output stalls, from the highest entry down. Input resumes
// as soon as the last read is issued, while that final result is still in
// the output register. group_size (register 0 at byte address 0, 7 bits,
// reset 64) takes zero as one and saturates at MAX_GROUP; a new size applies
// from the next element, so lowering it mid-group can close a group longer
// than the new size. The buffer needs no clearing after reset.
module block_reverse_reorder #(
   parameter int MAX_GROUP = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [brr_pkg::VALUE_W-1:0]       req_value,
   input  logic                              req_array_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [brr_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                              rsp_group_last,
   output logic                              rsp_array_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [brr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [brr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [brr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import brr_pkg::*;

   brr_cmd_type              cmd;
   brr_status_type           status;
   logic [GROUP_SIZE_W-1:0]  group_size_ff;
   logic                     sel_group_size;

   assign csr_pready     = 1'b1;
   assign sel_group_size = (csr_paddr[CSR_ADDR_W-1:2] == REG_GROUP_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_group_size) begin
         group_size_ff <= csr_pwdata[GROUP_SIZE_W-1:0];
      end
   end

   always_comb begin
      if (sel_group_size) begin
         csr_prdata = CSR_DATA_W'(group_size_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   brr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brr_datapath #(
      .MAX_GROUP (MAX_GROUP)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .group_size     (group_size_ff),
      .req_value      (req_value),
      .req_array_end  (req_array_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_group_last (rsp_group_last),
      .rsp_array_last (rsp_array_last)
   );

`ifndef SYNTH
   // An element that ends the array always closes its group and stops input.
   a_end_stops_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_array_end |=> !req_ready)
      else $error("input still open after an array_end transfer");

   // The end of the array is also the end of a group.
   a_array_last_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_array_last |-> rsp_group_last)
      else $error("array_last without group_last");

   // Results are only read out while the input is closed.
   a_emit_only_closed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result produced while the buffer was filling");
`endif

endmodule
